// ===== hdl/hsm_pkg.sv =====
// Shared constants, command/status types and a helper function for the similarity block.
package hsm_pkg;

    // Key store geometry
    localparam int MAX_KEYS         = 32;
    localparam int MAX_VECTOR_BYTES = 1024;
    localparam int KEY_W            = $clog2(MAX_KEYS);
    localparam int BYTE_W           = $clog2(MAX_VECTOR_BYTES);
    localparam int ADDR_W           = KEY_W + BYTE_W;
    localparam int MEM_DEPTH        = MAX_KEYS * MAX_VECTOR_BYTES;

    // Register and field widths
    localparam int VB_W   = 11;
    localparam int KC_W   = 6;
    localparam int CNT_W  = 14;
    localparam int SIM_W  = 16;
    localparam int QUO_W  = 16;
    localparam int STEP_W = $clog2(QUO_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [SIM_W-1:0] SIM_POS_MAX = {1'b0, {(SIM_W-1){1'b1}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT    = 1'b1;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;
        logic test_start;
        logic key_clr;
        logic key_inc;
        logic acc_rd;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_hit;
        logic byte_last;
        logic key_last;
        logic div_last;
        logic out_free;
    } t_stat;

    // Number of set bits in a byte
    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int b = 0; b < 8; b++) begin
            c = c + {3'd0, v[b]};
        end
        return c;
    endfunction

endpackage

// ===== hdl/hamming_similarity_matrix.sv =====
// Top level of the Hamming similarity block: controller plus datapath.
//
// Input channel (i_valid/o_ready): one beat carries kind, key_index, byte_index and
// data_byte. A key load beat writes one byte of the key store and is taken every cycle
// while the block is idle. A test beat is compared against key_count keys, one key
// store read per cycle, and the next beat is taken once the last key's count is updated;
// a test byte beyond vector_bytes skips the key pass. Byte index 0 clears all match counts.
// After the last test byte, one result beat per key leaves on o_valid/i_ready in key
// order, o_last marking the final key. Each result runs through a one-bit-per-cycle
// divider (load, 16 quotient steps, handoff to the output register); the next input
// beat is taken once the last result sits in the output register. If the receiver
// stalls, the finished result waits in the output register and the divider holds its
// next quotient until the register frees up.
// Config channel (i_cfg_valid/o_cfg_ready) is always ready; write only while idle.
// Reset (i_rst_n low, synchronous) clears counts, control and output valid and sets
// vector_bytes = 1024, key_count = 32. The key store is not cleared; load keys first.
module hamming_similarity_matrix
    import hsm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_kind,
    input  logic [KEY_W-1:0]        i_key_index,
    input  logic [BYTE_W-1:0]       i_byte_index,
    input  logic [7:0]              i_data_byte,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [KEY_W-1:0]        o_result_key,
    output logic signed [SIM_W-1:0] o_similarity,
    output logic                    o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    hsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Storage and arithmetic
    hsm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_key_index  (i_key_index),
        .i_byte_index (i_byte_index),
        .i_data_byte  (i_data_byte),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result_key (o_result_key),
        .o_similarity (o_similarity),
        .o_last       (o_last)
    );

endmodule

// ===== hdl/hsm_ctrl.sv =====
// Sequencer for key loads, per-byte accumulation, division and result handoff.
module hsm_ctrl
    import hsm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_kind,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_kind == KIND_LOAD) begin
                    o_cmd.load_wr = 1'b1;
                end
                if (w_accept && i_kind == KIND_TEST) begin
                    o_cmd.test_start = 1'b1;
                    o_cmd.key_clr    = 1'b1;
                    if (i_stat.in_hit) begin
                        n_state = S_ACC;
                    end
                end
            end
            S_ACC: begin
                // one key read per cycle
                o_cmd.acc_rd  = 1'b1;
                o_cmd.key_inc = 1'b1;
                if (i_stat.key_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last key's add lands here
                o_cmd.key_clr = 1'b1;
                n_state = i_stat.byte_last ? S_LOAD : S_IDLE;
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.key_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.key_inc = 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/hsm_dp.sv =====
// Datapath: config registers, key store, match counts, divider and output register.
module hsm_dp
    import hsm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [KEY_W-1:0]        i_key_index,
    input  logic [BYTE_W-1:0]       i_byte_index,
    input  logic [7:0]              i_data_byte,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [KEY_W-1:0]        o_result_key,
    output logic signed [SIM_W-1:0] o_similarity,
    output logic                    o_last
);

    // Config registers, held already clamped to their usable range
    logic [VB_W-1:0] r_vb;
    logic [KC_W-1:0] r_kc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= VB_W'(MAX_VECTOR_BYTES);
            r_kc <= KC_W'(MAX_KEYS);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VECTOR_BYTES: begin
                    if (i_cfg_data[VB_W-1:0] == '0) begin
                        r_vb <= VB_W'(1);
                    end else if (i_cfg_data[VB_W-1:0] > VB_W'(MAX_VECTOR_BYTES)) begin
                        r_vb <= VB_W'(MAX_VECTOR_BYTES);
                    end else begin
                        r_vb <= i_cfg_data[VB_W-1:0];
                    end
                end
                CFG_KEY_COUNT: begin
                    if (i_cfg_data[KC_W-1:0] == '0) begin
                        r_kc <= KC_W'(1);
                    end else if (i_cfg_data[KC_W-1:0] > KC_W'(MAX_KEYS)) begin
                        r_kc <= KC_W'(MAX_KEYS);
                    end else begin
                        r_kc <= i_cfg_data[KC_W-1:0];
                    end
                end
                default: begin
                    r_vb <= r_vb;
                end
            endcase
        end
    end

    // Current test byte and key counter
    logic [BYTE_W-1:0] r_pos;
    logic [7:0]        r_byte;
    logic [KEY_W-1:0]  r_key;

    always_ff @(posedge i_clk) begin
        if (i_cmd.test_start) begin
            r_pos  <= i_byte_index;
            r_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cmd.key_clr) begin
            r_key <= '0;
        end else if (i_cmd.key_inc) begin
            r_key <= r_key + KEY_W'(1);
        end
    end

    // Key store: one write or one read per cycle, registered read
    logic [7:0]       r_mem [MEM_DEPTH];
    logic [7:0]       r_rd_data;
    logic             r_rd_vld;
    logic [KEY_W-1:0] r_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem[{i_key_index, i_byte_index}] <= i_data_byte;
        end else if (i_cmd.acc_rd) begin
            r_rd_data <= r_mem[{r_key, r_pos}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.acc_rd;
        end
        r_rd_key <= r_key;
    end

    // Match counts; one read port shared by accumulate and divider load
    logic [CNT_W-1:0] r_cnt [MAX_KEYS];
    logic [KEY_W-1:0] w_cnt_addr;
    logic [CNT_W-1:0] w_cnt_rd;
    logic [CNT_W:0]   w_cnt_sum;

    assign w_cnt_addr = r_rd_vld ? r_rd_key : r_key;
    assign w_cnt_rd   = r_cnt[w_cnt_addr];
    assign w_cnt_sum  = {1'b0, w_cnt_rd} + (CNT_W+1)'(pop8(~(r_rd_data ^ r_byte)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_KEYS; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_cmd.test_start && i_byte_index == '0) begin
            for (int k = 0; k < MAX_KEYS; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (r_rd_vld) begin
            r_cnt[r_rd_key] <= w_cnt_sum[CNT_W] ? COUNT_MAX : w_cnt_sum[CNT_W-1:0];
        end
    end

    // Restoring divider: quotient = floor(count * 8192 / vector_bytes), one bit a cycle
    logic [VB_W-1:0]   r_rem;
    logic [QUO_W-1:0]  r_dvd;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_sat;
    logic [VB_W:0]     w_trial;
    logic              w_qbit;

    assign w_trial = {r_rem, r_dvd[QUO_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_vb});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            // at or above 1.0 the result saturates
            r_sat  <= (w_cnt_rd >= {r_vb, 3'b000});
            r_rem  <= w_cnt_rd[CNT_W-1:3];
            r_dvd  <= {w_cnt_rd[2:0], {(QUO_W-3){1'b0}}};
            r_quo  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_qbit ? VB_W'(w_trial - {1'b0, r_vb}) : w_trial[VB_W-1:0];
            r_dvd  <= {r_dvd[QUO_W-2:0], 1'b0};
            r_quo  <= {r_quo[QUO_W-2:0], w_qbit};
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Output register
    logic                    r_o_valid;
    logic [KEY_W-1:0]        r_o_key;
    logic signed [SIM_W-1:0] r_o_sim;
    logic                    r_o_last;
    logic                    w_key_last;

    assign w_key_last = ({1'b0, r_key} == r_kc - KC_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_key  <= r_key;
            // subtract the 1.0 offset by flipping the top quotient bit
            r_o_sim  <= r_sat ? SIM_POS_MAX : {~r_quo[QUO_W-1], r_quo[QUO_W-2:0]};
            r_o_last <= w_key_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_result_key = r_o_key;
    assign o_similarity = r_o_sim;
    assign o_last       = r_o_last;

    // Status toward the controller
    assign o_stat.in_hit    = ({1'b0, i_byte_index} < r_vb);
    assign o_stat.byte_last = ({1'b0, r_pos} == r_vb - VB_W'(1));
    assign o_stat.key_last  = w_key_last;
    assign o_stat.div_last  = (r_step == {STEP_W{1'b1}});
    assign o_stat.out_free  = !r_o_valid || i_ready;

endmodule

// ===== sim/hamming_similarity_matrix_tb.sv =====
// Self-checking testbench for the Hamming similarity block: directed extremes, then random traffic.
`timescale 1ns / 1ps

module hamming_similarity_matrix_tb;
    import hsm_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int DRAIN_CYCLES = 64;   // margin for the longest test byte, which reads all MAX_KEYS keys
    localparam int MAX_RUN      = 16;   // cap on one idle or stall stretch

    typedef struct {
        logic [KEY_W-1:0]        key;
        logic signed [SIM_W-1:0] sim;
        logic                    last;
    } t_score;

    // DUT ports
    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_cfg_valid  = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index  = CFG_VECTOR_BYTES;
    logic [CFG_DATA_W-1:0]   i_cfg_data   = '0;
    logic                    i_valid      = 1'b0;
    logic                    o_ready;
    logic                    i_kind       = KIND_LOAD;
    logic [KEY_W-1:0]        i_key_index  = '0;
    logic [BYTE_W-1:0]       i_byte_index = '0;
    logic [7:0]              i_data_byte  = '0;
    logic                    o_valid;
    logic                    i_ready      = 1'b0;
    logic [KEY_W-1:0]        o_result_key;
    logic signed [SIM_W-1:0] o_similarity;
    logic                    o_last;

    // Predictor state
    logic [7:0]      key_image [MEM_DEPTH];
    bit              key_written [MEM_DEPTH];
    int unsigned     match_tally [MAX_KEYS];
    logic [VB_W-1:0] cfg_vector_bytes = VB_W'(MAX_VECTOR_BYTES);
    logic [KC_W-1:0] cfg_key_count    = KC_W'(MAX_KEYS);
    t_score          pending_scores [$];

    int err_count   = 0;
    int send_idle   = 0;
    int recv_stall  = 0;
    int stall_run   = 0;
    int cycle_count = 0;

    hamming_similarity_matrix i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_key_index  (i_key_index),
        .i_byte_index (i_byte_index),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result_key (o_result_key),
        .o_similarity (o_similarity),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Effective sizes after clamping the registers
    function automatic int used_bytes();
        if (cfg_vector_bytes == 0) return 1;
        if (cfg_vector_bytes > MAX_VECTOR_BYTES) return MAX_VECTOR_BYTES;
        return int'(cfg_vector_bytes);
    endfunction

    function automatic int used_keys();
        if (cfg_key_count == 0) return 1;
        if (cfg_key_count > MAX_KEYS) return MAX_KEYS;
        return int'(cfg_key_count);
    endfunction

    // floor((2m - B) * 2^15 / B), B = 8 * bytes, clamped to Q1.15
    function automatic logic signed [SIM_W-1:0] q15_score(input int unsigned match_cnt,
                                                          input int nbytes);
        longint bits;
        longint num;
        longint quo;
        bits = longint'(nbytes) * 8;
        num  = (longint'(match_cnt) * 2 - bits) * 32768;
        quo  = num / bits;
        if (num % bits != 0 && num < 0) quo = quo - 1;
        if (quo > 32767) quo = 32767;
        if (quo < -32768) quo = -32768;
        return quo[SIM_W-1:0];
    endfunction

    // Update key image and match tallies for one accepted beat; queue the scores it yields
    task automatic score_beat(input logic kind, input logic [KEY_W-1:0] key,
                              input logic [BYTE_W-1:0] pos, input logic [7:0] data);
        int     nbytes;
        int     nkeys;
        int     addr;
        t_score r;
        nbytes = used_bytes();
        nkeys  = used_keys();
        if (kind == KIND_LOAD) begin
            addr = int'({key, pos});
            key_image[addr]   = data;
            key_written[addr] = 1'b1;
            return;
        end
        if (pos == 0) begin
            foreach (match_tally[k]) match_tally[k] = 0;
        end
        if (int'(pos) >= nbytes) return;
        for (int k = 0; k < nkeys; k++) begin
            addr = k * MAX_VECTOR_BYTES + int'(pos);
            match_tally[k] = match_tally[k] + $countones(~(data ^ key_image[addr]));
            if (match_tally[k] > COUNT_MAX) match_tally[k] = 32'(COUNT_MAX);
        end
        if (int'(pos) != nbytes - 1) return;
        for (int k = 0; k < nkeys; k++) begin
            r.key  = KEY_W'(k);
            r.sim  = q15_score(match_tally[k], nbytes);
            r.last = (k == nkeys - 1);
            pending_scores.push_back(r);
        end
    endtask

    // Send one input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic kind, input logic [KEY_W-1:0] key,
                             input logic [BYTE_W-1:0] pos, input logic [7:0] data);
        int gap;
        gap = 0;
        while (gap < MAX_RUN && $urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_key_index  <= key;
        i_byte_index <= pos;
        i_data_byte  <= data;
        do @(posedge i_clk); while (!o_ready);
        score_beat(kind, key, pos, data);
    endtask

    // Wait until every queued score has come out and the block has gone quiet
    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers, vector length first
    task automatic set_config(input logic [CFG_DATA_W-1:0] vb_data,
                              input logic [CFG_DATA_W-1:0] kc_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_VECTOR_BYTES;
        i_cfg_data  <= vb_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_vector_bytes = vb_data[VB_W-1:0];
        i_cfg_index <= CFG_KEY_COUNT;
        i_cfg_data  <= kc_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_key_count = kc_data[KC_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    // Load random bytes wherever the coming test vectors would read an unwritten entry
    task automatic fill_keys();
        for (int k = 0; k < used_keys(); k++) begin
            for (int p = 0; p < used_bytes(); p++) begin
                if (!key_written[k * MAX_VECTOR_BYTES + p])
                    send_beat(KIND_LOAD, KEY_W'(k), BYTE_W'(p), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Test bytes 0..len-1 with random content
    task automatic send_vector(input int len);
        for (int p = 0; p < len; p++) begin
            send_beat(KIND_TEST, KEY_W'($urandom_range(0, MAX_KEYS - 1)), BYTE_W'(p),
                      8'($urandom_range(0, 255)));
        end
    endtask

    // One-byte vectors against every key, both similarity extremes, bytes past the vector
    task automatic test_single_byte_vectors();
        send_idle  = 0;
        recv_stall = 0;
        settle_block();
        // zero length clamps to one byte, 63 keys clamps to the maximum
        set_config(11'd0, 11'd63);
        send_beat(KIND_LOAD, 5'd0, 10'd0, 8'h00);
        send_beat(KIND_LOAD, 5'd1, 10'd0, 8'hFF);
        send_beat(KIND_LOAD, 5'd31, 10'd0, 8'h5A);
        fill_keys();
        send_beat(KIND_TEST, 5'd0, 10'd0, 8'h00);
        send_beat(KIND_TEST, 5'd31, 10'd0, 8'hFF);
        // past the vector end: no scores
        send_beat(KIND_TEST, 5'd0, 10'd1, 8'h00);
        send_beat(KIND_TEST, 5'd0, 10'd1023, 8'hFF);
        send_beat(KIND_TEST, 5'd17, 10'd0, 8'hA5);
    endtask

    // Oversized length clamps to the maximum: only the first and the final byte are sent
    task automatic test_length_clamp();
        send_idle  = 0;
        recv_stall = 0;
        settle_block();
        // key count 0 in the low bits clamps to one
        set_config(11'h7FF, 11'h7C0);
        send_beat(KIND_LOAD, 5'd0, 10'd1023, 8'($urandom_range(0, 255)));
        send_beat(KIND_TEST, 5'd9, 10'd0, 8'($urandom_range(0, 255)));
        send_beat(KIND_TEST, 5'd3, 10'd1023, 8'($urandom_range(0, 255)));
    endtask

    // Repeat one byte index until the match count passes the vector size and the score clamps
    task automatic test_score_clamp();
        send_idle  = 0;
        recv_stall = 0;
        settle_block();
        set_config(11'd3, 11'd2);
        send_beat(KIND_LOAD, 5'd0, 10'd1, 8'h3C);
        send_beat(KIND_LOAD, 5'd1, 10'd1, 8'hC3);
        fill_keys();
        send_beat(KIND_TEST, 5'd0, 10'd0, 8'($urandom_range(0, 255)));
        repeat (40) send_beat(KIND_TEST, KEY_W'($urandom_range(0, MAX_KEYS - 1)), 10'd1,
                              8'h3C);
        send_beat(KIND_TEST, 5'd0, 10'd7, 8'h00);
        send_beat(KIND_TEST, 5'd0, 10'd2, 8'($urandom_range(0, 255)));
    endtask

    // Mostly whole vectors with random content; some truncated vectors, stray bytes, loads
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int pick;
        int sent;
        int len;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        repeat (2) begin
            settle_block();
            set_config(CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, MAX_KEYS)));
            fill_keys();
            sent = 0;
            while (sent < 28) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    send_vector(used_bytes());
                    sent += used_bytes();
                end else if (pick < 75) begin
                    len = $urandom_range(0, used_bytes() - 1);
                    send_vector(len);
                    sent += len;
                end else if (pick < 85) begin
                    send_beat(KIND_LOAD, KEY_W'($urandom_range(0, MAX_KEYS - 1)),
                              BYTE_W'($urandom_range(0, MAX_VECTOR_BYTES - 1)),
                              8'($urandom_range(0, 255)));
                    sent++;
                end else begin
                    if ($urandom_range(0, 1) == 0)
                        len = $urandom_range(0, used_bytes() - 1);
                    else
                        len = $urandom_range(0, MAX_VECTOR_BYTES - 1);
                    send_beat(KIND_TEST, KEY_W'($urandom_range(0, MAX_KEYS - 1)), BYTE_W'(len),
                              8'($urandom_range(0, 255)));
                    sent++;
                end
            end
        end
    endtask

    // Result beats: compare with the oldest queued score, then pick next cycle's ready
    always @(posedge i_clk) begin : score_check
        t_score want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_scores.size() == 0) begin
                $error("result beat with no score pending: key %0d", o_result_key);
                err_count++;
            end else begin
                want = pending_scores.pop_front();
                if (o_result_key !== want.key) begin
                    $error("result_key mismatch: expected %0d, actual %0d", want.key,
                           o_result_key);
                    err_count++;
                end
                if (o_similarity !== want.sim) begin
                    $error("similarity mismatch: expected %0d, actual %0d", want.sim,
                           o_similarity);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("last mismatch: expected %0d, actual %0d", want.last, o_last);
                    err_count++;
                end
            end
        end
        if (stall_run < MAX_RUN && $urandom_range(0, 99) < recv_stall) begin
            i_ready <= 1'b0;
            stall_run++;
        end else begin
            i_ready <= 1'b1;
            stall_run = 0;
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL hamming_similarity_matrix");
        $finish;
    end

    // Test sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_byte_vectors();
        test_length_clamp();
        test_score_clamp();
        test_random_traffic(0, 0);
        test_random_traffic(79, 0);
        test_random_traffic(0, 79);
        test_random_traffic(23, 23);
        settle_block();
        if (err_count == 0)
            $display("PASS hamming_similarity_matrix");
        else
            $display("FAIL hamming_similarity_matrix");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/hsm_pkg.sv
hdl/hsm_ctrl.sv
hdl/hsm_dp.sv
hdl/hamming_similarity_matrix.sv
sim/hamming_similarity_matrix_tb.sv
